FILE: design/led_and_segment_pattern_generator_unit_macros.svh
// Assertion macros shared by the pattern generator design.
`ifndef LED_AND_SEGMENT_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define LED_AND_SEGMENT_PATTERN_GENERATOR_UNIT_MACROS_SVH

// Check that cons holds whenever ante holds, outside reset.
`define LSPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define LSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lspg_pkg.sv
// Package: types and constants of the LED and segment pattern generator.
`timescale 1ns / 1ps

package lspg_pkg;

  localparam int LSPG_COUNTER_WIDTH = 32;

  // Tick dividers and animation spans.
  localparam int LSPG_BLINK_DIV  = 100;
  localparam int LSPG_SWEEP_DIV  = 5;
  localparam int LSPG_DIGIT_DIV  = 40;
  localparam int LSPG_SWEEP_SPAN = 30;
  localparam int LSPG_TWIN_SPAN  = 14;
  localparam int LSPG_DEC_BASE   = 10;

  localparam int LSPG_SWEEP_HALF = 16;
  localparam int LSPG_TWIN_HALF  = 8;
  localparam int LSPG_LED_W      = 16;

  // Widths of the phase counters.
  localparam int LSPG_R5_W   = $clog2(LSPG_SWEEP_DIV);
  localparam int LSPG_R40_W  = $clog2(LSPG_DIGIT_DIV);
  localparam int LSPG_R100_W = $clog2(LSPG_BLINK_DIV);
  localparam int LSPG_P30_W  = $clog2(LSPG_SWEEP_SPAN);
  localparam int LSPG_Q14_W  = $clog2(LSPG_TWIN_SPAN);

  // Mirror value and its serial BCD conversion.
  localparam int LSPG_BIN_W      = 15;
  localparam int LSPG_BCD_DIGITS = 5;
  localparam int LSPG_BCD_W      = 4 * LSPG_BCD_DIGITS;
  localparam int LSPG_CNT_DIGITS = 4;
  localparam int LSPG_CNT_W      = 4 * LSPG_CNT_DIGITS;
  localparam int LSPG_SEG_W      = 32;

  typedef struct packed {
    logic                   blink;
    logic [LSPG_P30_W-1:0]  sweep_p;
    logic [LSPG_Q14_W-1:0]  twin_q;
    logic [3:0]             digit;
    logic [LSPG_CNT_W-1:0]  dec_count;
  } lspg_tmr_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lspg_conv_status_t;

endpackage

FILE: design/lspg_bcd_conv.sv
// Bit-serial binary to packed BCD converter (shift and add three).
`timescale 1ns / 1ps

module lspg_bcd_conv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lspg_pkg::LSPG_BIN_W-1:0]  bin_in,
  output lspg_pkg::lspg_conv_status_t      status,
  output logic [lspg_pkg::LSPG_BCD_W-1:0]  bcd_out
);
  import lspg_pkg::*;

  localparam int CNT_W = $clog2(LSPG_BIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(LSPG_BIN_W - 1);

  logic [LSPG_BIN_W-1:0] bin_sr;
  logic [LSPG_BCD_W-1:0] bcd;
  logic [LSPG_BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < LSPG_BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_sr <= bin_in;
      bcd    <= '0;
    end else if (busy) begin
      bcd    <= {bcd_adj[LSPG_BCD_W-2:0], bin_sr[LSPG_BIN_W-1]};
      bin_sr <= {bin_sr[LSPG_BIN_W-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign bcd_out     = bcd;

endmodule

FILE: design/lspg_tick_timer.sv
// Tick counter with running remainders for the animation and display timers.
`timescale 1ns / 1ps

module lspg_tick_timer #(
  parameter int COUNTER_WIDTH = lspg_pkg::LSPG_COUNTER_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  output lspg_pkg::lspg_tmr_status_t    status
);
  import lspg_pkg::*;

  localparam logic [LSPG_R5_W-1:0]   R5_LAST   = LSPG_R5_W'(LSPG_SWEEP_DIV - 1);
  localparam logic [LSPG_R40_W-1:0]  R40_LAST  = LSPG_R40_W'(LSPG_DIGIT_DIV - 1);
  localparam logic [LSPG_R100_W-1:0] R100_LAST = LSPG_R100_W'(LSPG_BLINK_DIV - 1);
  localparam logic [LSPG_P30_W-1:0]  P30_LAST  = LSPG_P30_W'(LSPG_SWEEP_SPAN - 1);
  localparam logic [LSPG_Q14_W-1:0]  Q14_LAST  = LSPG_Q14_W'(LSPG_TWIN_SPAN - 1);
  localparam logic [3:0]             DEC_LAST  = 4'(LSPG_DEC_BASE - 1);

  logic [COUNTER_WIDTH-1:0] tick;
  logic [LSPG_R5_W-1:0]     r5;
  logic [LSPG_R40_W-1:0]    r40;
  logic [LSPG_R100_W-1:0]   r100;
  logic [LSPG_P30_W-1:0]    p30;
  logic [LSPG_Q14_W-1:0]    q14;
  logic [3:0]               d10;
  logic                     blink;
  logic [LSPG_CNT_W-1:0]    dec_count;
  logic [LSPG_CNT_W-1:0]    dec_count_next;

  // Decimal increment, one digit carrying into the next.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < LSPG_CNT_DIGITS; i++) begin
      if (carry && dec_count[4*i +: 4] == DEC_LAST) begin
        dec_count_next[4*i +: 4] = 4'd0;
      end else begin
        dec_count_next[4*i +: 4] = dec_count[4*i +: 4] + {3'd0, carry};
        carry = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      r5        <= '0;
      r40       <= '0;
      r100      <= '0;
      p30       <= '0;
      q14       <= '0;
      d10       <= '0;
      blink     <= 1'b0;
      dec_count <= '0;
    end else if (advance) begin
      if (tick == '1) begin
        // Counter wraps: every derived value restarts at zero.
        tick      <= '0;
        r5        <= '0;
        r40       <= '0;
        r100      <= '0;
        p30       <= '0;
        q14       <= '0;
        d10       <= '0;
        blink     <= 1'b0;
        dec_count <= '0;
      end else begin
        tick      <= tick + 1'b1;
        dec_count <= dec_count_next;
        if (r5 == R5_LAST) begin
          r5  <= '0;
          p30 <= (p30 == P30_LAST) ? '0 : p30 + 1'b1;
          q14 <= (q14 == Q14_LAST) ? '0 : q14 + 1'b1;
        end else begin
          r5 <= r5 + 1'b1;
        end
        if (r40 == R40_LAST) begin
          r40 <= '0;
          d10 <= (d10 == DEC_LAST) ? 4'd0 : d10 + 4'd1;
        end else begin
          r40 <= r40 + 1'b1;
        end
        if (r100 == R100_LAST) begin
          r100  <= '0;
          blink <= ~blink;
        end else begin
          r100 <= r100 + 1'b1;
        end
      end
    end
  end

  assign status.blink     = blink;
  assign status.sweep_p   = p30;
  assign status.twin_q    = q14;
  assign status.digit     = d10;
  assign status.dec_count = dec_count;

endmodule

FILE: design/led_and_segment_pattern_generator_unit.sv
// Top level: LED and seven-segment pattern generator.
`timescale 1ns / 1ps
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+--------------------------
//  switch   | switch_valid  | switch_stall  | switch_bits[15:0]
//  result   | result_valid  | result_stall  | led_bits[15:0], segment_bcd[31:0]
//
//  Work stage: a pattern-mode item is ready there in the cycle after it is
//  accepted; a mirror-mode item (switch 15 on) waits there while the
//  bit-serial BCD converter shifts in the 15 switch bits, one a cycle.
//  Reset: synchronous rst clears the tick counter, its remainders and all
//  valid flags. Stalls: the output register holds a result under
//  result_stall while the work stage can take the next item.

module led_and_segment_pattern_generator_unit #(
  parameter int COUNTER_WIDTH = lspg_pkg::LSPG_COUNTER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                switch_valid,
  output logic                                switch_stall,
  input  logic [15:0]                         switch_bits,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [lspg_pkg::LSPG_LED_W-1:0]     led_bits,
  output logic [lspg_pkg::LSPG_SEG_W-1:0]     segment_bcd
);
  import lspg_pkg::*;

  localparam int SWEEP_POS_W = $clog2(LSPG_LED_W);
  localparam int TWIN_POS_W  = $clog2(LSPG_TWIN_HALF);

  lspg_tmr_status_t  tmr;
  lspg_conv_status_t conv;

  logic                  accept;
  logic                  work_valid;
  logic                  work_mirror;
  logic [LSPG_LED_W-1:0] work_led;
  logic [LSPG_SEG_W-1:0] work_seg;
  logic                  work_ready;
  logic                  out_load;
  logic [LSPG_BCD_W-1:0] conv_bcd;

  logic [LSPG_LED_W-1:0] led_next;
  logic [LSPG_SEG_W-1:0] seg_next;
  logic [SWEEP_POS_W-1:0] sweep_pos;
  logic [TWIN_POS_W-1:0]  twin_pos;

  // Take a new item only when the work stage is empty.
  assign switch_stall = work_valid;
  assign accept       = switch_valid && !switch_stall;

  // Count every accepted item, mirror mode included.
  lspg_tick_timer #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_timer (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .status (tmr)
  );

  // Convert the mirrored switch value to decimal, one bit a cycle.
  lspg_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && switch_bits[15]),
    .bin_in (switch_bits[LSPG_BIN_W-1:0]),
    .status (conv),
    .bcd_out(conv_bcd)
  );

  // Fold the sweep and bounce phases into LED positions.
  always_comb begin
    sweep_pos = (tmr.sweep_p < LSPG_P30_W'(LSPG_SWEEP_HALF))
              ? SWEEP_POS_W'(tmr.sweep_p)
              : SWEEP_POS_W'(LSPG_P30_W'(LSPG_SWEEP_SPAN) - tmr.sweep_p);
    twin_pos  = (tmr.twin_q < LSPG_Q14_W'(LSPG_TWIN_HALF))
              ? TWIN_POS_W'(tmr.twin_q)
              : TWIN_POS_W'(LSPG_Q14_W'(LSPG_TWIN_SPAN) - tmr.twin_q);
  end

  // Form the LED and display words from the switches and the timer.
  always_comb begin
    if (switch_bits[15]) begin
      led_next = {1'b0, switch_bits[LSPG_BIN_W-1:0]};
    end else if (!switch_bits[1]) begin
      if (switch_bits[0]) begin
        led_next = tmr.blink ? '1 : '0;
      end else begin
        led_next = LSPG_LED_W'(1) << sweep_pos;
      end
    end else if (switch_bits[0]) begin
      // Mirrored halves: the two dots meet in the middle.
      led_next = (LSPG_LED_W'(1) << twin_pos) |
                 (LSPG_LED_W'(1) << (SWEEP_POS_W'(LSPG_LED_W - 1) - {1'b0, twin_pos}));
    end else begin
      // Parallel halves: the upper dot tracks the lower one.
      led_next = (LSPG_LED_W'(1) << twin_pos) |
                 (LSPG_LED_W'(1) << {1'b1, twin_pos});
    end

    if (!switch_bits[3]) begin
      seg_next = '0;
    end else if (switch_bits[2]) begin
      seg_next = {(LSPG_SEG_W / 4){tmr.digit}};
    end else begin
      seg_next = {{(LSPG_SEG_W - LSPG_CNT_W){1'b0}}, tmr.dec_count};
    end
  end

  // Hold the item in the work stage until its display word is complete.
  assign work_ready = work_valid && !conv.busy;
  assign out_load   = work_ready && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (accept) begin
      work_valid <= 1'b1;
    end else if (out_load) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_mirror <= switch_bits[15];
      work_led    <= led_next;
      work_seg    <= seg_next;
    end
  end

  // Output register: load when free or being drained, drop after the take.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      led_bits    <= work_led;
      segment_bcd <= work_mirror
                   ? {{(LSPG_SEG_W - LSPG_BCD_W){1'b0}}, conv_bcd}
                   : work_seg;
    end
  end

  `include "led_and_segment_pattern_generator_unit_macros.svh"

  `LSPG_ASSERT_NEXT(a_mirror_starts_conv, accept && switch_bits[15], conv.busy, "mirror item did not start the converter")
  `LSPG_ASSERT_SAME(a_conv_done_has_item, conv.done, work_valid && work_mirror, "converter finished with no mirror item waiting")
  `LSPG_ASSERT_SAME(a_phase_in_range, 1'b1, (tmr.sweep_p < LSPG_P30_W'(LSPG_SWEEP_SPAN)) && (tmr.twin_q < LSPG_Q14_W'(LSPG_TWIN_SPAN)) && (tmr.digit < 4'(LSPG_DEC_BASE)), "timer phase out of range")

endmodule

FILE: test/tb_top.sv
// Testbench: LED and seven-segment pattern generator, checked item by item.
`timescale 1ns / 1ps

module tb_top;
  import lspg_pkg::*;

  // Run the block with a 16-bit tick counter, narrower than its default.
  localparam int TICK_W = 16;

  // Switch bit roles.
  localparam int SW_ALT    = 0;   // blink / mirrored twin halves
  localparam int SW_TWIN   = 1;   // twin 8-LED bounce
  localparam int SW_SAME   = 2;   // all digits equal
  localparam int SW_SHOW   = 3;   // display enable
  localparam int SW_MIRROR = 15;  // mirror mode

  localparam logic [15:0] MIRROR_MASK = 16'h7FFF;
  localparam logic [15:0] LEDS_ALL    = 16'hFFFF;
  localparam logic [31:0] DIGIT_REP   = 32'h1111_1111;
  localparam int          DEC_RANGE   = 10000;

  // Stimulus sizes and idling schedule.
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE_ITEMS  = 370;   // items per idling phase
  localparam int HOLD_AT      = 800;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [LSPG_LED_W-1:0] leds;
    logic [LSPG_SEG_W-1:0] seg;
  } lamp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  switch_valid = 1'b0;
  logic                  switch_stall;
  logic [15:0]           switch_bits  = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [LSPG_LED_W-1:0] led_bits;
  logic [LSPG_SEG_W-1:0] segment_bcd;

  logic [15:0] switch_plan[$];   // items still to offer
  lamp_word_t  lamp_due[$];      // predicted words, oldest first
  logic [TICK_W-1:0] tick_now = '0;
  logic switch_taken = 1'b0;
  logic hold_off     = 1'b0;
  int   items_in     = 0;
  int   plan_total   = 0;
  int   mismatches   = 0;

  always #5 clk = ~clk;

  led_and_segment_pattern_generator_unit #(
    .COUNTER_WIDTH(TICK_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .switch_valid (switch_valid),
    .switch_stall (switch_stall),
    .switch_bits  (switch_bits),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .led_bits     (led_bits),
    .segment_bcd  (segment_bcd)
  );

  // Pack a binary value into eight BCD nibbles, leading zeros as zero nibbles.
  function automatic logic [31:0] packed_decimal(input int unsigned v);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return acc;
  endfunction

  // Work out the LED and display words for one tick.
  function automatic lamp_word_t lamp_pattern(input logic [15:0] sw, input int unsigned t);
    lamp_word_t  w;
    int unsigned p;
    int unsigned loc;
    w.leds = '0;
    w.seg  = '0;
    if (sw[SW_MIRROR]) begin
      w.leds = sw & MIRROR_MASK;
      w.seg  = packed_decimal(sw & MIRROR_MASK);
    end else begin
      if (!sw[SW_SHOW])
        w.seg = '0;
      else if (sw[SW_SAME])
        w.seg = ((t / LSPG_DIGIT_DIV) % LSPG_DEC_BASE) * DIGIT_REP;
      else
        w.seg = packed_decimal(t % DEC_RANGE);

      if (!sw[SW_TWIN]) begin
        if (sw[SW_ALT]) begin
          // Blink: all on during odd hundreds of ticks.
          w.leds = ((t / LSPG_BLINK_DIV) % 2) ? LEDS_ALL : '0;
        end else begin
          // Ping-pong sweep 0..15..1.
          p = (t / LSPG_SWEEP_DIV) % LSPG_SWEEP_SPAN;
          if (p >= LSPG_SWEEP_HALF)
            p = LSPG_SWEEP_SPAN - p;
          w.leds[p] = 1'b1;
        end
      end else begin
        // Twin bounce 0..7..1 in each half, mirrored or parallel.
        loc = (t / LSPG_SWEEP_DIV) % LSPG_TWIN_SPAN;
        if (loc >= LSPG_TWIN_HALF)
          loc = LSPG_TWIN_SPAN - loc;
        w.leds[loc] = 1'b1;
        if (sw[SW_ALT])
          w.leds[15 - loc] = 1'b1;
        else
          w.leds[8 + loc] = 1'b1;
      end
    end
    return w;
  endfunction

  // Idle odds of each side by phase: sender light / receiver heavy, then
  // swapped, then none. Never idle the sender during the long hold-off.
  function automatic int send_idle_pct();
    if (hold_off)
      return 0;
    if (items_in < PHASE_ITEMS)
      return 19;
    if (items_in < 2 * PHASE_ITEMS)
      return 82;
    return 0;
  endfunction

  function automatic int take_idle_pct();
    if (items_in < PHASE_ITEMS)
      return 82;
    if (items_in < 2 * PHASE_ITEMS)
      return 19;
    return 0;
  endfunction

  // Reset: hold from time zero, release on a falling edge, never again.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Driver: offer the next item once the current one is taken, hold it while
  // stalled, and drop valid on random idle cycles.
  always @(negedge clk) begin
    if (!rst) begin
      if (!switch_valid || switch_taken) begin
        if (switch_plan.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          switch_valid <= 1'b1;
          switch_bits  <= switch_plan.pop_front();
        end else begin
          switch_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, and solidly during the hold-off.
  always @(negedge clk) begin
    result_stall <= hold_off || ($urandom_range(99) < take_idle_pct());
  end

  // Long hold-off: keep the result side stalled so the block backs up into
  // its input while items keep coming.
  initial begin
    while (items_in < HOLD_AT)
      @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: predict on each accepted item, then check each accepted result
  // against the oldest prediction.
  always @(posedge clk) begin
    lamp_word_t want;
    int         bad;
    bad = 0;
    if (rst) begin
      tick_now     <= '0;
      switch_taken <= 1'b0;
    end else begin
      switch_taken <= switch_valid && !switch_stall;
      if (switch_valid && !switch_stall) begin
        lamp_due.push_back(lamp_pattern(switch_bits, tick_now));
        tick_now <= tick_now + 1'b1;
        items_in <= items_in + 1;
      end
      if (result_valid && !result_stall) begin
        if (lamp_due.size() == 0) begin
          $display("%0t: unexpected result led_bits %h segment_bcd %h",
                   $time, led_bits, segment_bcd);
          bad = bad + 1;
        end else begin
          want = lamp_due.pop_front();
          if (led_bits !== want.leds) begin
            $display("%0t: led_bits expected %h got %h", $time, want.leds, led_bits);
            bad = bad + 1;
          end
          if (segment_bcd !== want.seg) begin
            $display("%0t: segment_bcd expected %h got %h", $time, want.seg, segment_bcd);
            bad = bad + 1;
          end
        end
      end
      if (bad != 0)
        mismatches <= mismatches + bad;
    end
  end

  // Stimulus plan, then drain and verdict.
  initial begin
    logic [15:0] sw;
    // Directed: every mode and pattern select, field extremes, mirror values.
    switch_plan.push_back(16'h0000);               // sweep, blank display
    switch_plan.push_back(16'hFFFF);               // mirror, largest value
    switch_plan.push_back(16'h8000);               // mirror of zero
    switch_plan.push_back(16'h7FFF);               // high bits ignored outside mirror
    switch_plan.push_back(16'h7FF0);
    for (int m = 1; m < 16; m++)
      switch_plan.push_back(m[15:0]);              // every pattern/display select
    switch_plan.push_back(16'h8001);
    switch_plan.push_back(16'h8000 | 16'd9999);
    switch_plan.push_back(16'h8000 | 16'd12345);
    switch_plan.push_back(16'hAAAA);
    switch_plan.push_back(16'hD555);

    // Random: a mix of mirror and pattern items with random upper bits.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sw = 16'($urandom());
      sw[SW_MIRROR] = ($urandom_range(99) < 30);
      switch_plan.push_back(sw);
    end
    plan_total = switch_plan.size();

    while (items_in < plan_total)
      @(posedge clk);
    while (lamp_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && lamp_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
